@@ rtl/core/kwm_pkg.sv @@
// Shared types, constants and helper functions of the k-way run merge block.
package kwm_pkg;

    // Run bookkeeping.
    localparam int MAX_RUNS = 16;
    localparam int RUN_W    = $clog2(MAX_RUNS);
    localparam int CNT_W    = 5;

    // Field widths.
    localparam int COORD_W  = 32;
    localparam int TAG_W    = 32;
    localparam int TOTAL_W  = 32;
    localparam int AXIS_W   = 2;
    localparam int CFG_W    = 5;

    // Axis codes; the remaining codes order by z.
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

    // Configuration register indexes.
    localparam logic CFG_SORT_AXIS   = 1'b0;
    localparam logic CFG_ACTIVE_RUNS = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [AXIS_W-1:0] SORT_AXIS_RST   = AXIS_X;
    localparam logic [CNT_W-1:0]  ACTIVE_RUNS_RST = CNT_W'(MAX_RUNS);

    // Saturation value of the emitted object count.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // One stored run head.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic        [TAG_W-1:0]   tag;
    } t_head;

    // Control of the minimum scan unit.
    typedef struct packed {
        logic             clear;
        logic             cmp_en;
        logic [RUN_W-1:0] idx;
    } t_scan_ctl;

    // Number of runs that take part, clamped into 1..MAX_RUNS.
    function automatic logic [CNT_W-1:0] live_runs(input logic [CFG_W-1:0] active);
        logic [CNT_W-1:0] n;
        if (active == '0) begin
            n = CNT_W'(1);
        end else if (active > CFG_W'(MAX_RUNS)) begin
            n = CNT_W'(MAX_RUNS);
        end else begin
            n = active;
        end
        return n;
    endfunction

    // Sort key of a head on the selected axis.
    function automatic logic signed [COORD_W-1:0] key_of(input t_head h,
                                                         input logic [AXIS_W-1:0] axis);
        logic signed [COORD_W-1:0] k;
        case (axis)
            AXIS_X:  k = h.x;
            AXIS_Y:  k = h.y;
            default: k = h.z;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/core/kwm_head_mem.sv @@
// Head store: one synchronous memory entry per run with a registered read port.
module kwm_head_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [kwm_pkg::RUN_W-1:0]  i_waddr,
    input  kwm_pkg::t_head             i_wdata,
    input  logic [kwm_pkg::RUN_W-1:0]  i_raddr,
    output kwm_pkg::t_head             o_rdata
);

    kwm_pkg::t_head r_mem [kwm_pkg::MAX_RUNS];
    kwm_pkg::t_head r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/kwm_min_scan.sv @@
// Running minimum over the heads streamed out of the head store.
module kwm_min_scan (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kwm_pkg::t_scan_ctl              i_ctl,
    input  kwm_pkg::t_head                  i_head,
    input  logic                            i_head_valid,
    input  logic [kwm_pkg::AXIS_W-1:0]      i_axis,
    output logic                            o_found,
    output logic [kwm_pkg::RUN_W-1:0]       o_best_idx
);

    logic                                r_found;
    logic [kwm_pkg::RUN_W-1:0]           r_best_idx;
    logic signed [kwm_pkg::COORD_W-1:0]  r_best_key;
    logic signed [kwm_pkg::COORD_W-1:0]  key;
    logic                                take;

    // A strictly smaller key wins, so ties keep the lower run index.
    assign key  = kwm_pkg::key_of(i_head, i_axis);
    assign take = i_ctl.cmp_en && i_head_valid && (!r_found || (key < r_best_key));

    // Found flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    // Best index and key.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_idx <= i_ctl.idx;
            r_best_key <= key;
        end
    end

    assign o_found    = r_found;
    assign o_best_idx = r_best_idx;

endmodule

@@ rtl/core/kway_run_merge.sv @@
// Top level of the k-way run merge: fill and refill control, head scan and result register.
//
// Usage: the input channel (i_in_valid / o_in_ready) takes head requests from the runs.
// During the fill, runs 0, 1, ... report in order, each with its first object or as
// exhausted. After that only the run named by the last result's refill_run is taken;
// a request from any other run is accepted and dropped. The output channel
// (o_out_valid / i_out_ready) carries one result per completed fill or refill:
// the smallest head on the configured axis, or a final result with merge_done set.
// Steps: for a request that triggers a result, the scan reads the head store one entry per
// cycle over the live runs (active_runs clamped into 1..16), a drain step finishes the last
// compare, a fetch step reads the winning entry and the emit step loads the result register.
// No request is taken from the start of the scan until the result is loaded.
// A fill request that does not finish the fill leaves the block idle. The input is taken again
// as soon as the result is loaded, even while the receiver has not yet taken it; a
// stalled receiver holds the next result back in the last step. Configuration writes go
// through the plain write port at any edge and are meant for idle periods.
// Reset (synchronous, active low) clears all head valid flags, counters and the result register;
// after the final result no more requests are taken until reset.
module kway_run_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration.
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [kwm_pkg::CFG_W-1:0]         i_cfg_data,
    // Input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [kwm_pkg::RUN_W-1:0]         i_run_index,
    input  logic                              i_run_exhausted,
    input  logic signed [kwm_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [kwm_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [kwm_pkg::COORD_W-1:0] i_center_z,
    input  logic [kwm_pkg::TAG_W-1:0]         i_object_tag,
    // Output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [kwm_pkg::COORD_W-1:0] o_out_x,
    output logic signed [kwm_pkg::COORD_W-1:0] o_out_y,
    output logic signed [kwm_pkg::COORD_W-1:0] o_out_z,
    output logic [kwm_pkg::TAG_W-1:0]         o_out_tag,
    output logic [kwm_pkg::RUN_W-1:0]         o_refill_run,
    output logic                              o_merge_done,
    output logic [kwm_pkg::TOTAL_W-1:0]       o_emitted_count
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_EMIT
    } t_state;

    t_state                          r_state;
    logic [kwm_pkg::AXIS_W-1:0]      r_sort_axis;
    logic [kwm_pkg::CFG_W-1:0]       r_active_runs;
    logic [kwm_pkg::MAX_RUNS-1:0]    r_head_valid;
    logic [kwm_pkg::CNT_W-1:0]       r_fill_count;
    logic [kwm_pkg::RUN_W-1:0]       r_awaited_run;
    logic [kwm_pkg::TOTAL_W-1:0]     r_emit_total;
    logic                            r_finished;
    logic [kwm_pkg::RUN_W-1:0]       r_scan_idx;
    logic                            r_cmp_vld;
    logic [kwm_pkg::RUN_W-1:0]       r_cmp_idx;

    logic                            r_out_valid;
    kwm_pkg::t_head                  r_out_head;
    logic [kwm_pkg::RUN_W-1:0]       r_out_run;
    logic                            r_out_done;
    logic [kwm_pkg::TOTAL_W-1:0]     r_out_count;

    logic [kwm_pkg::CNT_W-1:0]       live;
    logic                            in_acc;
    logic                            hit;
    logic                            fill_open;
    logic [kwm_pkg::CNT_W-1:0]       n_fill_count;
    logic                            start_scan;
    logic                            scan_last;
    logic                            out_free;
    logic                            n_out_valid;
    logic [kwm_pkg::TOTAL_W-1:0]     n_emit_total;
    kwm_pkg::t_head                  wr_head;
    kwm_pkg::t_head                  rd_head;
    logic [kwm_pkg::RUN_W-1:0]       rd_addr;
    kwm_pkg::t_scan_ctl              scan_ctl;
    logic                            best_found;
    logic [kwm_pkg::RUN_W-1:0]       best_idx;

    // Request decode and fill progress.
    assign live         = kwm_pkg::live_runs(r_active_runs);
    assign o_in_ready   = (r_state == ST_IDLE) && !r_finished;
    assign in_acc       = i_in_valid && o_in_ready;
    assign hit          = in_acc && (i_run_index == r_awaited_run);
    assign fill_open    = r_fill_count < live;
    assign n_fill_count = r_fill_count + kwm_pkg::CNT_W'(1);
    assign start_scan   = hit && (!fill_open || (n_fill_count >= live));
    assign scan_last    = ({1'b0, r_scan_idx} == (live - kwm_pkg::CNT_W'(1)));
    assign out_free     = !r_out_valid || i_out_ready;
    assign n_out_valid  = ((r_state == ST_EMIT) && out_free) || (r_out_valid && !i_out_ready);
    assign n_emit_total = (r_emit_total == kwm_pkg::TOTAL_MAX) ?
                          r_emit_total : r_emit_total + kwm_pkg::TOTAL_W'(1);

    assign wr_head.x   = i_center_x;
    assign wr_head.y   = i_center_y;
    assign wr_head.z   = i_center_z;
    assign wr_head.tag = i_object_tag;

    // Read address: scan pointer while scanning, then the winning run until it is loaded.
    assign rd_addr = ((r_state == ST_FETCH) || (r_state == ST_EMIT)) ? best_idx : r_scan_idx;

    assign scan_ctl.clear  = start_scan;
    assign scan_ctl.cmp_en = r_cmp_vld;
    assign scan_ctl.idx    = r_cmp_idx;

    kwm_head_mem u_head_mem (
        .i_clk   (i_clk),
        .i_we    (hit && !i_run_exhausted),
        .i_waddr (r_awaited_run),
        .i_wdata (wr_head),
        .i_raddr (rd_addr),
        .o_rdata (rd_head)
    );

    kwm_min_scan u_min_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_head       (rd_head),
        .i_head_valid (r_head_valid[r_cmp_idx]),
        .i_axis       (r_sort_axis),
        .o_found      (best_found),
        .o_best_idx   (best_idx)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_axis   <= kwm_pkg::SORT_AXIS_RST;
            r_active_runs <= kwm_pkg::ACTIVE_RUNS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kwm_pkg::CFG_SORT_AXIS:   r_sort_axis   <= i_cfg_data[kwm_pkg::AXIS_W-1:0];
                kwm_pkg::CFG_ACTIVE_RUNS: r_active_runs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: fill tracking, head scan, result loading.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_head_valid  <= '0;
            r_fill_count  <= '0;
            r_awaited_run <= '0;
            r_emit_total  <= '0;
            r_finished    <= 1'b0;
            r_scan_idx    <= '0;
            r_cmp_vld     <= 1'b0;
            r_cmp_idx     <= '0;
            r_out_valid   <= 1'b0;
            r_out_head    <= '0;
            r_out_run     <= '0;
            r_out_done    <= 1'b0;
            r_out_count   <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                ST_IDLE: begin
                    r_cmp_vld <= 1'b0;
                    if (hit) begin
                        r_head_valid[r_awaited_run] <= !i_run_exhausted;
                        if (fill_open) begin
                            r_fill_count <= n_fill_count;
                            if (n_fill_count < live) begin
                                r_awaited_run <= n_fill_count[kwm_pkg::RUN_W-1:0];
                            end
                        end
                        if (start_scan) begin
                            r_scan_idx <= '0;
                            r_state    <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_cmp_vld  <= 1'b1;
                    r_cmp_idx  <= r_scan_idx;
                    r_scan_idx <= r_scan_idx + kwm_pkg::RUN_W'(1);
                    if (scan_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_cmp_vld <= 1'b0;
                    r_state   <= ST_FETCH;
                end
                ST_FETCH: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                        if (best_found) begin
                            r_out_head               <= rd_head;
                            r_out_run                <= best_idx;
                            r_out_done               <= 1'b0;
                            r_out_count              <= n_emit_total;
                            r_emit_total             <= n_emit_total;
                            r_head_valid[best_idx]   <= 1'b0;
                            r_awaited_run            <= best_idx;
                        end else begin
                            r_out_head  <= '0;
                            r_out_run   <= '0;
                            r_out_done  <= 1'b1;
                            r_out_count <= '0;
                            r_finished  <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_x         = r_out_head.x;
    assign o_out_y         = r_out_head.y;
    assign o_out_z         = r_out_head.z;
    assign o_out_tag       = r_out_head.tag;
    assign o_refill_run    = r_out_run;
    assign o_merge_done    = r_out_done;
    assign o_emitted_count = r_out_count;

endmodule

@@ rtl/core/kwm_checker.sv @@
// Port-level checks of the k-way run merge and their attachment to the top level.
module kwm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic [kwm_pkg::TAG_W-1:0]         o_out_tag,
    input  logic [kwm_pkg::RUN_W-1:0]         o_refill_run,
    input  logic                              o_merge_done,
    input  logic [kwm_pkg::TOTAL_W-1:0]       o_emitted_count
);

    // A stalled result keeps its content.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_tag) && $stable(o_emitted_count))
        else $error("result changed while stalled");

    // The final result carries nothing but its done flag.
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_merge_done |->
            (o_out_tag == '0) && (o_refill_run == '0) && (o_emitted_count == '0))
        else $error("final result with nonzero fields");

    // Every object result counts at least itself.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_merge_done |-> (o_emitted_count != '0))
        else $error("object result with zero count");

    // Once the final result is taken, no more requests are accepted.
    a_no_input_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_merge_done |=> !o_in_ready)
        else $error("request taken after the final result");

endmodule

bind kway_run_merge kwm_checker u_kwm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_out_tag       (o_out_tag),
    .o_refill_run    (o_refill_run),
    .o_merge_done    (o_merge_done),
    .o_emitted_count (o_emitted_count)
);

@@ sim/kway_run_merge_test.sv @@
// Self-checking testbench of the k-way run merge: directed and random head requests, scoreboard.
module kway_run_merge_test;
    import kwm_pkg::*;

    // Axis codes that the package leaves unnamed; both order by z.
    localparam logic [AXIS_W-1:0] AXIS_Z     = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_Z_ALT = 2'd3;

    // Coordinate extremes of signed Q16.16.
    localparam logic signed [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] Q_MAX = ~Q_MIN;

    // Run at which the extended fill is cut short by a smaller run count.
    localparam logic [RUN_W-1:0] SPLIT_RUN  = 4'd10;
    localparam logic [CFG_W-1:0] SPLIT_SPAN = 5'd8;

    // Timing of the run.
    localparam int SETTLE_CYCLES = 2 * MAX_RUNS + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;

    // One result as it leaves the block.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic        [TAG_W-1:0]   tag;
        logic        [RUN_W-1:0]   refill;
        logic                      done;
        logic        [TOTAL_W-1:0] count;
    } merge_emit_t;

    // Predicts the merge from every accepted request and checks the emitted results.
    class merge_scoreboard;
        logic [AXIS_W-1:0]  axis;
        logic [CFG_W-1:0]   active_runs;
        t_head              heads[MAX_RUNS];
        bit                 head_ok[MAX_RUNS];
        int unsigned        fill_count;
        logic [RUN_W-1:0]   awaited;
        logic [TOTAL_W-1:0] emit_total;
        bit                 finished;
        merge_emit_t        expected_emits[$];
        int unsigned        failures;

        function new();
            axis        = SORT_AXIS_RST;
            active_runs = ACTIVE_RUNS_RST;
            foreach (head_ok[i]) head_ok[i] = 1'b0;
            fill_count  = 0;
            awaited     = '0;
            emit_total  = '0;
            finished    = 1'b0;
            failures    = 0;
        endfunction

        function void set_register(logic index, logic [CFG_W-1:0] data);
            if (index == CFG_SORT_AXIS) begin
                axis = data[AXIS_W-1:0];
            end else begin
                active_runs = data;
            end
        endfunction

        // Number of runs in the scan, with the register clamped into range.
        function int unsigned run_span();
            if (active_runs == 0) begin
                return 1;
            end
            if (active_runs > MAX_RUNS) begin
                return MAX_RUNS;
            end
            return active_runs;
        endfunction

        function logic signed [COORD_W-1:0] sort_key(int unsigned slot);
            case (axis)
                AXIS_X:  return heads[slot].x;
                AXIS_Y:  return heads[slot].y;
                default: return heads[slot].z;
            endcase
        endfunction

        function logic [RUN_W-1:0] waiting_run();
            return awaited;
        endfunction

        function bit merge_finished();
            return finished;
        endfunction

        function int unsigned pending();
            return expected_emits.size();
        endfunction

        // Run 0 is never exhausted at random, and enough other heads must stay.
        function bit may_exhaust();
            int unsigned i;
            int unsigned held;
            held = 0;
            for (i = 0; i < run_span(); i++) begin
                if (head_ok[i] && i != awaited) held++;
            end
            return awaited != 0 && held >= 5;
        endfunction

        // Applies one accepted request and queues the result it causes, if any.
        function void take_request(logic [RUN_W-1:0] run, bit exhausted, t_head obj);
            merge_emit_t r;
            int unsigned i;
            int unsigned span;
            int unsigned best;
            bit          found;
            if (finished || run != awaited) begin
                return;
            end
            if (exhausted) begin
                head_ok[awaited] = 1'b0;
            end else begin
                head_ok[awaited] = 1'b1;
                heads[awaited]   = obj;
            end
            span = run_span();
            if (fill_count < span) begin
                fill_count++;
                if (fill_count < span) begin
                    awaited = RUN_W'(fill_count);
                    return;
                end
            end
            // Smallest head on the axis; the first one found wins a tie.
            found = 1'b0;
            best  = 0;
            for (i = 0; i < span; i++) begin
                if (head_ok[i] && (!found || sort_key(i) < sort_key(best))) begin
                    best  = i;
                    found = 1'b1;
                end
            end
            r = '0;
            if (!found) begin
                r.done   = 1'b1;
                finished = 1'b1;
            end else begin
                if (emit_total != TOTAL_MAX) emit_total++;
                r.x           = heads[best].x;
                r.y           = heads[best].y;
                r.z           = heads[best].z;
                r.tag         = heads[best].tag;
                r.refill      = RUN_W'(best);
                r.count       = emit_total;
                head_ok[best] = 1'b0;
                awaited       = RUN_W'(best);
            end
            expected_emits.insert(expected_emits.size(), r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_emit(merge_emit_t seen);
            merge_emit_t want;
            if (expected_emits.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got %h",
                         $time, seen);
                failures++;
                return;
            end
            want = expected_emits.pop_front();
            compare_field("out_x", want.x, seen.x);
            compare_field("out_y", want.y, seen.y);
            compare_field("out_z", want.z, seen.z);
            compare_field("out_tag", want.tag, seen.tag);
            compare_field("refill_run", 32'(want.refill), 32'(seen.refill));
            compare_field("merge_done", 32'(want.done), 32'(seen.done));
            compare_field("emitted_count", want.count, seen.count);
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic                      i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [RUN_W-1:0]          i_run_index;
    logic                      i_run_exhausted;
    logic signed [COORD_W-1:0] i_center_x;
    logic signed [COORD_W-1:0] i_center_y;
    logic signed [COORD_W-1:0] i_center_z;
    logic [TAG_W-1:0]          i_object_tag;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [COORD_W-1:0] o_out_x;
    logic signed [COORD_W-1:0] o_out_y;
    logic signed [COORD_W-1:0] o_out_z;
    logic [TAG_W-1:0]          o_out_tag;
    logic [RUN_W-1:0]          o_refill_run;
    logic                      o_merge_done;
    logic [TOTAL_W-1:0]        o_emitted_count;

    merge_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    bit              hold_receiver;

    kway_run_merge u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_run_index     (i_run_index),
        .i_run_exhausted (i_run_exhausted),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_center_z      (i_center_z),
        .i_object_tag    (i_object_tag),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_out_tag       (o_out_tag),
        .o_refill_run    (o_refill_run),
        .o_merge_done    (o_merge_done),
        .o_emitted_count (o_emitted_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Coordinates lean toward the extremes and a narrow band, so ties are common.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        logic signed [COORD_W-1:0] c;
        case ($urandom_range(0, 7))
            0:       c = Q_MIN;
            1:       c = Q_MAX;
            2:       c = 0;
            3:       c = -1;
            4, 5:    c = $urandom_range(0, 15) - 8;
            default: c = $urandom();
        endcase
        return c;
    endfunction

    function automatic t_head random_head();
        t_head h;
        h.x = pick_coord();
        h.y = pick_coord();
        h.z = pick_coord();
        case ($urandom_range(0, 9))
            0:       h.tag = '0;
            1:       h.tag = '1;
            default: h.tag = $urandom();
        endcase
        return h;
    endfunction

    // Writes both registers; called at a falling edge while the block is idle.
    task automatic configure(input logic [AXIS_W-1:0] axis, input logic [CFG_W-1:0] runs);
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_SORT_AXIS;
        i_cfg_data  = CFG_W'(axis);
        @(posedge i_clk);
        sb.set_register(CFG_SORT_AXIS, CFG_W'(axis));
        @(negedge i_clk);
        i_cfg_index = CFG_ACTIVE_RUNS;
        i_cfg_data  = runs;
        @(posedge i_clk);
        sb.set_register(CFG_ACTIVE_RUNS, runs);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Offers one head request and returns at the falling edge after it is taken.
    task automatic send_request(input logic [RUN_W-1:0] run, input bit exhausted,
                                input t_head obj);
        bit taken;
        i_run_index     = run;
        i_run_exhausted = exhausted;
        i_center_x      = obj.x;
        i_center_y      = obj.y;
        i_center_z      = obj.z;
        i_object_tag    = obj.tag;
        i_in_valid      = 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_in_ready;
        end
        sb.take_request(run, exhausted, obj);
        @(negedge i_clk);
    endtask

    task automatic sender_pause();
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // Holds requests back until every result has come and the block has gone quiet.
    task automatic settle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly refills of the awaited run, some requests from other runs.
    task automatic random_burst(input int unsigned items, input int unsigned hold_at);
        int unsigned      sent;
        logic [RUN_W-1:0] run;
        bit               exhausted;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 99) < 12) begin
                run       = sb.waiting_run() + RUN_W'($urandom_range(1, MAX_RUNS - 1));
                exhausted = 1'($urandom_range(0, 1));
            end else begin
                run       = sb.waiting_run();
                exhausted = sb.may_exhaust() && ($urandom_range(0, 99) < 3);
                sent++;
                if (hold_at != 0 && sent == hold_at) hold_receiver = 1'b1;
            end
            send_request(run, exhausted, random_head());
            sender_pause();
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int unsigned stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                stall_left    = HOLD_CYCLES;
                hold_receiver = 1'b0;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Every result taken by the receiver goes to the scoreboard.
    always @(posedge i_clk) begin : emit_monitor
        merge_emit_t seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.x      = o_out_x;
            seen.y      = o_out_y;
            seen.z      = o_out_z;
            seen.tag    = o_out_tag;
            seen.refill = o_refill_run;
            seen.done   = o_merge_done;
            seen.count  = o_emitted_count;
            sb.check_emit(seen);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        sb              = new();
        send_idle_pct   = 15;
        recv_idle_pct   = 52;
        hold_receiver   = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_SORT_AXIS;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_run_index     = '0;
        i_run_exhausted = 1'b0;
        i_center_x      = '0;
        i_center_y      = '0;
        i_center_z      = '0;
        i_object_tag    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill of five runs: a stray request, extremes, an empty run and a tie on x.
        configure(AXIS_X, 5'd5);
        send_request(4'd9, 1'b0, random_head());
        send_request(sb.waiting_run(), 1'b0, '{x: Q_MIN, y: Q_MAX, z: 0, tag: 0});
        send_request(sb.waiting_run(), 1'b0, '{x: Q_MAX, y: Q_MIN, z: -1, tag: -1});
        send_request(sb.waiting_run(), 1'b1, '{x: -1, y: -1, z: -1, tag: -1});
        send_request(sb.waiting_run(), 1'b0, '{x: Q_MIN, y: 0, z: Q_MAX, tag: 3});
        send_request(sb.waiting_run(), 1'b0, '{x: 0, y: -1, z: Q_MIN, tag: 4});

        // Refills: another tie, a plain refill, a stray run, then an exhausted run.
        send_request(sb.waiting_run(), 1'b0, '{x: Q_MIN, y: 1, z: 1, tag: 5});
        send_request(sb.waiting_run(), 1'b0, '{x: 1, y: Q_MAX, z: 0, tag: 6});
        send_request(sb.waiting_run() + 4'd1, 1'b0, random_head());
        send_request(sb.waiting_run(), 1'b1, random_head());

        // Each axis code in turn.
        settle();
        configure(AXIS_Y, 5'd5);
        send_request(sb.waiting_run(), 1'b0, '{x: 0, y: Q_MIN, z: Q_MAX, tag: 7});
        settle();
        configure(AXIS_Z, 5'd5);
        send_request(sb.waiting_run(), 1'b0, '{x: Q_MAX, y: 0, z: Q_MIN, tag: 8});
        settle();
        configure(AXIS_Z_ALT, 5'd5);
        send_request(sb.waiting_run(), 1'b0, random_head());

        // More runs mid-merge reopen the fill; fewer runs then close it early.
        settle();
        configure(AXIS_X, CFG_W'(MAX_RUNS));
        while (sb.waiting_run() != SPLIT_RUN) begin
            send_request(sb.waiting_run(), 1'b0, random_head());
        end
        settle();
        configure(AXIS_X, SPLIT_SPAN);
        send_request(sb.waiting_run(), 1'b0, random_head());

        // Random merging: sender idles seldom, receiver often, with one long hold-off.
        settle();
        configure(AXIS_Y, CFG_W'(MAX_RUNS));
        random_burst(200, 100);

        // Receiver idles seldom, sender often; run counts out of range and small.
        settle();
        send_idle_pct = 52;
        recv_idle_pct = 15;
        configure(AXIS_Z_ALT, 5'd31);
        random_burst(80, 0);
        settle();
        configure(AXIS_X, 5'd0);
        random_burst(50, 0);
        settle();
        configure(AXIS_Z, 5'd3);
        random_burst(70, 0);

        // No idling on either side.
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(AXIS_Y, CFG_W'(MAX_RUNS));
        random_burst(150, 0);

        // Exhaust every awaited run until the final result.
        while (!sb.merge_finished()) begin
            send_request(sb.waiting_run(), 1'b1, random_head());
        end
        settle();

        if (sb.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/kwm_pkg.sv
rtl/core/kwm_head_mem.sv
rtl/core/kwm_min_scan.sv
rtl/core/kway_run_merge.sv
rtl/core/kwm_checker.sv
sim/kway_run_merge_test.sv
